// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, sampled on the rising edge and held off while in reset.
`define ASSERT_CLKED(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Implication that must hold in the same cycle as its trigger.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLKED(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== rtl/ubxfr_pkg.sv =====
`default_nettype none

package ubxfr_pkg;

	// Sync pair, frame layout and the reset value of the length limit.
	localparam logic [7:0]  SYNC_FIRST   = 8'hB5;
	localparam logic [7:0]  SYNC_SECOND  = 8'h62;
	localparam logic [9:0]  LIMIT_RESET  = 10'd127;
	localparam logic [10:0] HEADER_BYTES = 11'd6;
	localparam logic [16:0] CKSUM_BYTES  = 17'd2;

	// Receiver state carried from one byte to the next.
	typedef struct packed {
		logic        in_frame;
		logic [10:0] position;
		logic [7:0]  length_low;
		logic [9:0]  remaining;
	} ubxfr_state_t;

	// Result of one byte, if any.
	typedef struct packed {
		logic        valid;
		logic [7:0]  data_byte;
		logic [10:0] offset;
		logic        last;
		logic        reject;
	} ubxfr_result_t;

endpackage

`default_nettype wire

// ===== rtl/ubxfr_parse.sv =====
`default_nettype none

module ubxfr_parse (
	input  wire logic [7:0]             rx_byte,
	input  wire logic [9:0]             count_limit,
	input  wire ubxfr_pkg::ubxfr_state_t cur,
	output ubxfr_pkg::ubxfr_state_t      nxt,
	output ubxfr_pkg::ubxfr_result_t     res
);
	import ubxfr_pkg::*;

	logic [10:0] pos_inc;
	logic [9:0]  rem_dec;
	logic [16:0] total;

	assign pos_inc = cur.position + 11'd1;
	assign rem_dec = cur.remaining - 10'd1;
	assign total   = {1'b0, rx_byte, cur.length_low} + CKSUM_BYTES;

	// Frame state update and result for one received byte.
	always_comb begin
		nxt           = cur;
		res           = '0;
		res.data_byte = rx_byte;
		res.offset    = cur.position - 11'd2;
		if (!cur.in_frame) begin
			// Hunting for the first sync byte.
			if (rx_byte == SYNC_FIRST) begin
				nxt.in_frame = 1'b1;
				nxt.position = 11'd1;
			end
		end else if (cur.position <= 11'd1) begin
			// A wrong second sync byte drops back to hunting without a recheck.
			if (rx_byte != SYNC_SECOND) begin
				nxt.in_frame = 1'b0;
			end else begin
				nxt.position = 11'd2;
			end
		end else begin
			nxt.position = pos_inc;
			res.valid    = 1'b1;
			if (pos_inc < HEADER_BYTES) begin
				if (pos_inc == HEADER_BYTES - 11'd1) begin
					nxt.length_low = rx_byte;
				end
			end else if (pos_inc == HEADER_BYTES) begin
				// Length high byte: check the frame against the limit.
				if (total > {7'd0, count_limit}) begin
					nxt.in_frame = 1'b0;
					res.reject   = 1'b1;
				end else begin
					nxt.remaining = total[9:0];
				end
			end else begin
				nxt.remaining = rem_dec;
				if (rem_dec == 10'd0) begin
					nxt.in_frame = 1'b0;
					nxt.position = 11'd0;
					res.last     = 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ubx_frame_receiver.sv =====
// A byte accepted into the input register is loaded into the result register, from
// which its result can be taken; sync and hunting bytes give no result.
// Throughput: one byte per cycle; the input register frees whenever the result
// register is empty or being taken, so only output stall holds the input back.
// Reset (arst_n low, asynchronous): hunting for sync, no result pending, the
// limit register back to 127.
`default_nettype none

module ubx_frame_receiver (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Received byte channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	// Frame byte channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       data_byte,
	output logic [10:0]      offset,
	output logic             last,
	output logic             reject,
	// Limit register write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [9:0]  count_limit
);
	import ubxfr_pkg::*;

	logic          valid_s1;
	logic [7:0]    rx_byte_s1;
	logic [9:0]    limit_q;
	ubxfr_state_t  state_q;
	ubxfr_state_t  state_nxt;
	ubxfr_result_t res;
	logic          out_valid_q;
	logic [7:0]    data_q;
	logic [10:0]   offset_q;
	logic          last_q;
	logic          reject_q;
	logic          adv_s1;

	// The input register moves on when the result register can take a request.
	assign adv_s1    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv_s1;
	assign cfg_ready = 1'b1;

	// Limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= count_limit;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	ubxfr_parse u_parse (
		.rx_byte     (rx_byte_s1),
		.count_limit (limit_q),
		.cur         (state_q),
		.nxt         (state_nxt),
		.res         (res)
	);

	// Frame state advances once per byte leaving the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= res.valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.valid) begin
			data_q   <= res.data_byte;
			offset_q <= res.offset;
			last_q   <= res.last;
			reject_q <= res.reject;
		end
	end

	assign out_valid = out_valid_q;
	assign data_byte = data_q;
	assign offset    = offset_q;
	assign last      = last_q;
	assign reject    = reject_q;

endmodule

`default_nettype wire

// ===== rtl/ubxfr_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module ubxfr_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic [10:0] offset,
	input  wire logic        last,
	input  wire logic        reject
);

	// A stalled result stays put.
	`ASSERT_CLKED(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(offset), "stalled result changed")

	// A frame cannot both end and be rejected.
	`ASSERT_IMPL(a_last_xor_reject, clk, arst_n, out_valid, !(last && reject), "last and reject together")

	// Rejection is only flagged on the length high byte.
	`ASSERT_IMPL(a_reject_offset, clk, arst_n, out_valid && reject, offset == 11'd3, "reject away from length byte")

	// The end mark comes after the header and both checksum bytes.
	`ASSERT_IMPL(a_last_offset, clk, arst_n, out_valid && last, offset >= 11'd5, "end mark too early")

endmodule

bind ubx_frame_receiver ubxfr_checker u_ubxfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.data_byte (data_byte),
	.offset    (offset),
	.last      (last),
	.reject    (reject)
);

`default_nettype wire

// ===== test/tb_ubx_frame_receiver.sv =====
`timescale 1ns / 1ps

module tb_ubx_frame_receiver;

	import ubxfr_pkg::*;

	localparam int unsigned TIMEOUT_CYCLES = 400_000;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned PHASE_RESULTS  = 200;

	// One frame byte as the block should deliver it.
	typedef struct packed {
		logic [7:0]  data;
		logic [10:0] off;
		logic        last_mark;
		logic        rej;
	} frame_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  data_byte;
	logic [10:0] offset;
	logic        last;
	logic        reject;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [9:0]  count_limit = LIMIT_RESET;

	// Shadow of the receiver state and of its limit register.
	logic        frm_active = 1'b0;
	logic [10:0] frm_position = 11'd0;
	logic [7:0]  frm_len_low = 8'h00;
	logic [9:0]  frm_remaining = 10'd0;
	logic [9:0]  limit_setting = LIMIT_RESET;

	frame_byte_t expected_frame_bytes[$];

	int unsigned send_idle_pct = 35;
	int unsigned recv_idle_pct = 75;
	int unsigned cycle_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned results_predicted = 0;
	int unsigned bytes_checked = 0;
	int unsigned frames_done = 0;
	int unsigned frames_rejected = 0;
	int unsigned limit_writes = 0;
	int unsigned error_count = 0;

	ubx_frame_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_byte(data_byte),
		.offset(offset),
		.last(last),
		.reject(reject),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.count_limit(count_limit)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Advance the shadow state by one received byte and queue the frame byte it yields.
	function automatic void track_frame_byte(input logic [7:0] rx);
		logic [10:0] off;
		logic [16:0] total;
		frame_byte_t res;
		if (!frm_active) begin
			if (rx == SYNC_FIRST) begin
				frm_active = 1'b1;
				frm_position = 11'd1;
			end
			return;
		end
		// A wrong second sync byte is dropped, not taken as a new first sync byte.
		if (frm_position <= 11'd1) begin
			if (rx != SYNC_SECOND)
				frm_active = 1'b0;
			else
				frm_position = 11'd2;
			return;
		end
		off = frm_position - 11'd2;
		frm_position = frm_position + 11'd1;
		res.data = rx;
		res.off = off;
		res.last_mark = 1'b0;
		res.rej = 1'b0;
		if (frm_position < HEADER_BYTES) begin
			if (frm_position == HEADER_BYTES - 11'd1)
				frm_len_low = rx;
		end else if (frm_position == HEADER_BYTES) begin
			// The length check is made at full width, so 0xFFFF cannot wrap round.
			total = {1'b0, rx, frm_len_low} + CKSUM_BYTES;
			if (total > {7'd0, limit_setting}) begin
				frm_active = 1'b0;
				res.rej = 1'b1;
			end else begin
				frm_remaining = total[9:0];
			end
		end else begin
			frm_remaining = frm_remaining - 10'd1;
			if (frm_remaining == 10'd0) begin
				frm_active = 1'b0;
				frm_position = 11'd0;
				res.last_mark = 1'b1;
			end
		end
		expected_frame_bytes.push_back(res);
		results_predicted++;
	endfunction

	function automatic void check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			error_count++;
		end
	endfunction

	// Every accepted request on the byte channel goes through the shadow model.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			bytes_sent++;
			track_frame_byte(rx_byte);
		end
	end

	// Compare each delivered frame byte with the oldest one predicted.
	always @(posedge clk) begin : check_frame_byte
		frame_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_frame_bytes.size() == 0) begin
				$error("unexpected frame byte 0x%0h at offset %0d", data_byte, offset);
				error_count++;
			end else begin
				want = expected_frame_bytes.pop_front();
				check_field("data_byte", want.data, data_byte);
				check_field("offset", want.off, offset);
				check_field("last", want.last_mark, last);
				check_field("reject", want.rej, reject);
				bytes_checked++;
				if (want.last_mark)
					frames_done++;
				if (want.rej)
					frames_rejected++;
			end
		end
	end

	// Random back-pressure on the frame byte channel.
	always @(posedge clk) begin
		out_stall <= (recv_idle_pct != 0) && ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Guard against a hang.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > TIMEOUT_CYCLES) begin
			$display("timeout after %0d cycles, %0d frame bytes outstanding", cycle_count,
				expected_frame_bytes.size());
			$display("ubx_frame_receiver verification failed");
			$finish;
		end
	end

	// Offer one byte, after idle cycles drawn one at a time, and hold it until it is taken.
	task automatic send_byte(input logic [7:0] value);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_header(input logic [7:0] cls, input logic [7:0] id,
		input logic [15:0] len);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(cls);
		send_byte(id);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
	endtask

	// A frame with random payload and checksum; a frame the limit refuses stops at its header.
	task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
		input logic [15:0] len);
		send_header(cls, id, len);
		if (int'(len) + 2 <= int'(limit_setting))
			repeat (int'(len) + 2) send_byte(8'($urandom_range(0, 255)));
	endtask

	// Stop offering bytes and let the block empty before touching the register.
	// The first edge lets the last accepted request reach the shadow model.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_frame_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count_limit(input logic [9:0] value);
		wait_for_idle();
		cfg_valid <= 1'b1;
		count_limit <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		limit_setting = value;
		limit_writes++;
	endtask

	// Mostly short lengths, some long ones, and some just or far beyond the limit.
	function automatic logic [15:0] pick_frame_length(input logic [9:0] limit);
		int cap;
		int unsigned r;
		cap = int'(limit) - 2;
		r = $urandom_range(0, 99);
		if (r < 6)
			return 16'(cap + 1);
		if (r < 12)
			return 16'($urandom_range(65535, cap + 1));
		if (r < 20 && cap > 16)
			return 16'($urandom_range(cap, 17));
		return 16'($urandom_range((cap < 16) ? cap : 16, 0));
	endfunction

	// Stray bytes, a bad second sync byte, and one that is not rechecked as a first.
	task automatic test_hunting();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(SYNC_SECOND);
		send_byte(SYNC_FIRST);
		send_byte(8'h00);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_frame(8'h01, 8'h02, 16'd0);
	endtask

	// Field extremes, sync values inside a payload, and over-long lengths.
	task automatic test_frame_fields();
		send_frame(8'h00, 8'hFF, 16'd0);
		send_header(8'hFF, 8'h00, 16'd4);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hA5);
		send_byte(8'h5A);
		send_frame(8'h06, 8'h01, 16'hFFFF);
		send_frame(8'h06, 8'h02, 16'hFFFE);
		send_frame(8'h06, 8'h03, 16'h0100);
	endtask

	// The limit after reset admits exactly 125 payload bytes.
	task automatic test_reset_limit();
		send_frame(8'h0A, 8'h04, 16'(LIMIT_RESET) - 16'd2);
		send_frame(8'h0A, 8'h05, 16'(LIMIT_RESET) - 16'd1);
	endtask

	// Limits below two refuse everything; the largest limit gives the largest offset.
	task automatic test_limit_extremes();
		write_count_limit(10'd0);
		send_frame(8'h01, 8'h07, 16'd0);
		write_count_limit(10'd1);
		send_frame(8'h01, 8'h07, 16'd0);
		write_count_limit(10'd2);
		send_frame(8'h01, 8'h07, 16'd0);
		send_frame(8'h01, 8'h07, 16'd1);
		write_count_limit(10'd1023);
		send_frame(8'h02, 8'h13, 16'd1022);
		send_frame(8'h02, 8'h13, 16'd1021);
	endtask

	task automatic run_traffic_phase(input int unsigned sender_pct,
		input int unsigned receiver_pct, input logic [9:0] limit);
		int unsigned start;
		int unsigned pick;
		logic [7:0] stray;
		write_count_limit(limit);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		start = results_predicted;
		while (results_predicted - start < PHASE_RESULTS) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				repeat ($urandom_range(1, 4)) begin
					stray = 8'($urandom_range(0, 255));
					if (stray == SYNC_FIRST)
						stray = 8'h00;
					send_byte(stray);
				end
			end else if (pick < 20) begin
				stray = 8'($urandom_range(0, 255));
				if (stray == SYNC_SECOND)
					stray = SYNC_FIRST;
				send_byte(SYNC_FIRST);
				send_byte(stray);
			end else begin
				send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					pick_frame_length(limit_setting));
			end
		end
	endtask

	// Well-formed frames with random content, mixed with noise, under each idling mix.
	task automatic test_random_traffic();
		run_traffic_phase(35, 75, 10'd40);
		run_traffic_phase(75, 35, 10'd300);
		run_traffic_phase(0, 0, 10'($urandom_range(120, 2)));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_hunting();
		test_frame_fields();
		test_reset_limit();
		test_limit_extremes();
		test_random_traffic();
		wait_for_idle();
		$display("Sent %0d bytes, checked %0d frame bytes: %0d frames completed, %0d rejected.",
			bytes_sent, bytes_checked, frames_done, frames_rejected);
		$display("Limit written %0d times from 0 to 1023, under three stall and gap mixes.",
			limit_writes);
		if (error_count == 0)
			$display("ubx_frame_receiver verification clean");
		else
			$display("ubx_frame_receiver verification failed");
		$finish;
	end

endmodule
